// ===== src/cst_pkg.sv =====
// Package for the counting semaphore table: operation and status codes,
// default sizes and the request type passed from front to back. No dependencies.
package cst_pkg;
    localparam int NUM_SEMS_DEF   = 32;
    localparam int NUM_PROCS_DEF  = 64;
    localparam int COUNT_BITS_DEF = 16;
    localparam int NAME_BITS_DEF  = 64;

    localparam int OP_W   = 3;
    localparam int SID_W  = 5;
    localparam int PID_W  = 6;
    localparam int INIT_W = 16;
    localparam int KEY_W  = 64;
    localparam int ST_W   = 3;

    localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
    localparam logic [OP_W-1:0] OP_WAIT   = 3'd2;
    localparam logic [OP_W-1:0] OP_SIGNAL = 3'd3;
    localparam logic [OP_W-1:0] OP_NAME   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NAME_NULL = 3'd1;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_ID    = 3'd4;
    localparam logic [ST_W-1:0] ST_WAITERS   = 3'd5;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [SID_W-1:0]  sem_id;
        logic [PID_W-1:0]  proc_id;
        logic [INIT_W-1:0] init_value;
        logic [KEY_W-1:0]  name_key;
    } req_t;

    localparam int RES_W = ST_W + SID_W + 1 + 1 + PID_W + KEY_W;
endpackage

// ===== src/cst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/cst_queue.sv =====
// Two-entry request queue between the front and back parts.
// Depends on cst_pkg.
module cst_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  cst_pkg::req_t in_req,
    output logic          out_valid,
    input  logic          out_ready,
    output cst_pkg::req_t out_req
);
    cst_pkg::req_t buf_reg [2];
    logic          wptr_reg, rptr_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = buf_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wptr_reg] <= in_req;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= !wptr_reg;
            if (pop) rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== src/cst_front.sv =====
// Front part: accepts requests, masks the name key to NAME_BITS and
// saturates init_value to the count range. Depends on cst_pkg.
module cst_front #(
    parameter int COUNT_BITS = cst_pkg::COUNT_BITS_DEF,
    parameter int NAME_BITS  = cst_pkg::NAME_BITS_DEF
) (
    input  logic          s_valid,
    output logic          s_ready,
    input  cst_pkg::req_t s_req,
    output logic          q_valid,
    input  logic          q_ready,
    output cst_pkg::req_t q_req
);
    localparam logic [cst_pkg::KEY_W-1:0] KEY_MASK =
        {cst_pkg::KEY_W{1'b1}} >> (cst_pkg::KEY_W - NAME_BITS);
    localparam logic [cst_pkg::INIT_W-1:0] CMAX_INIT =
        (COUNT_BITS >= cst_pkg::INIT_W) ? {cst_pkg::INIT_W{1'b1}}
        : cst_pkg::INIT_W'((32'd1 << COUNT_BITS) - 32'd1);

    assign q_valid = s_valid;
    assign s_ready = q_ready;

    always_comb begin
        q_req = s_req;
        q_req.name_key = s_req.name_key & KEY_MASK;
        if (s_req.init_value > CMAX_INIT) q_req.init_value = CMAX_INIT;
    end
endmodule

// ===== src/cst_back.sv =====
// Back part: executes one request at a time on the semaphore table.
// Depends on cst_pkg and cst_ram (next-waiter links).
module cst_back #(
    parameter int NUM_SEMS   = cst_pkg::NUM_SEMS_DEF,
    parameter int NUM_PROCS  = cst_pkg::NUM_PROCS_DEF,
    parameter int COUNT_BITS = cst_pkg::COUNT_BITS_DEF,
    parameter int NAME_BITS  = cst_pkg::NAME_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  cst_pkg::req_t             q_req,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [cst_pkg::RES_W-1:0] m_data
);
    localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_LINK, S_OUT} state_t;

    state_t state_reg;
    cst_pkg::req_t req_reg;
    logic [COUNT_BITS-1:0] count_reg [NUM_SEMS];
    logic [NAME_BITS-1:0]  name_reg  [NUM_SEMS];
    logic [NUM_SEMS-1:0]   used_reg, nonempty_reg;
    logic [PW-1:0]         head_reg  [NUM_SEMS];
    logic [PW-1:0]         tail_reg  [NUM_SEMS];
    logic [SW:0]           scan_reg;
    logic                  found_reg, dup_reg;
    logic [SW-1:0]         slot_reg;
    logic [cst_pkg::ST_W-1:0] st_reg;
    logic [cst_pkg::SID_W-1:0] nid_reg;
    logic                  blk_reg, wk_reg;
    logic [cst_pkg::PID_W-1:0] wpid_reg;
    logic [cst_pkg::KEY_W-1:0] nout_reg;

    logic          ram_we;
    logic [PW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

    logic          sid_ok, pid_ok;
    logic [SW-1:0] scan_idx;

    assign scan_idx = scan_reg[SW-1:0];

    cst_ram #(.WIDTH(PW), .DEPTH(NUM_PROCS)) u_next (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [SW-1:0] rsid;
    assign rsid   = SW'(req_reg.sem_id);
    assign sid_ok = ({{(32-cst_pkg::SID_W){1'b0}}, req_reg.sem_id} < 32'(NUM_SEMS))
                    && used_reg[rsid];
    assign pid_ok = {{(32-cst_pkg::PID_W){1'b0}}, req_reg.proc_id} < 32'(NUM_PROCS);

    assign ram_raddr = head_reg[rsid];
    assign ram_we    = (state_reg == S_EXEC) && (req_reg.operation == cst_pkg::OP_WAIT)
                       && sid_ok && (count_reg[rsid] == '0) && pid_ok && nonempty_reg[rsid];
    assign ram_waddr = tail_reg[rsid];
    assign ram_wdata = PW'(req_reg.proc_id);

    assign q_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = {nout_reg, wpid_reg, wk_reg, blk_reg, nid_reg, st_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            nonempty_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        req_reg   <= q_req;
                        st_reg    <= cst_pkg::ST_OK;
                        nid_reg   <= '0;
                        blk_reg   <= 1'b0;
                        wk_reg    <= 1'b0;
                        wpid_reg  <= '0;
                        nout_reg  <= '0;
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                        dup_reg   <= 1'b0;
                        slot_reg  <= '0;
                        if (q_req.operation == cst_pkg::OP_CREATE
                            && q_req.name_key != '0) begin
                            state_reg <= S_SCAN;
                        end else begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_SCAN: begin
                    if (used_reg[scan_idx]
                        && name_reg[scan_idx] == NAME_BITS'(req_reg.name_key)) begin
                        dup_reg <= 1'b1;
                    end
                    if (!used_reg[scan_idx] && !found_reg) begin
                        found_reg <= 1'b1;
                        slot_reg  <= scan_idx;
                    end
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == (SW+1)'(NUM_SEMS - 1)) state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    state_reg <= S_OUT;
                    case (req_reg.operation)
                        cst_pkg::OP_CREATE: begin
                            if (req_reg.name_key == '0) st_reg <= cst_pkg::ST_NAME_NULL;
                            else if (dup_reg) st_reg <= cst_pkg::ST_DUPLICATE;
                            else if (!found_reg) st_reg <= cst_pkg::ST_FULL;
                            else begin
                                used_reg[slot_reg]     <= 1'b1;
                                name_reg[slot_reg]     <= NAME_BITS'(req_reg.name_key);
                                count_reg[slot_reg]    <= COUNT_BITS'(req_reg.init_value);
                                nonempty_reg[slot_reg] <= 1'b0;
                                nid_reg <= cst_pkg::SID_W'(slot_reg);
                            end
                        end
                        cst_pkg::OP_FREE: begin
                            if (!sid_ok) st_reg <= cst_pkg::ST_BAD_ID;
                            else if (nonempty_reg[rsid]) st_reg <= cst_pkg::ST_WAITERS;
                            else begin
                                used_reg[rsid]  <= 1'b0;
                                count_reg[rsid] <= '0;
                                name_reg[rsid]  <= '0;
                            end
                        end
                        cst_pkg::OP_WAIT: begin
                            if (!sid_ok) st_reg <= cst_pkg::ST_BAD_ID;
                            else if (count_reg[rsid] != '0)
                                count_reg[rsid] <= count_reg[rsid] - 1'b1;
                            else if (!pid_ok) st_reg <= cst_pkg::ST_BAD_ID;
                            else begin
                                if (!nonempty_reg[rsid]) begin
                                    head_reg[rsid]     <= PW'(req_reg.proc_id);
                                    nonempty_reg[rsid] <= 1'b1;
                                end
                                tail_reg[rsid] <= PW'(req_reg.proc_id);
                                blk_reg <= 1'b1;
                            end
                        end
                        cst_pkg::OP_SIGNAL: begin
                            if (!sid_ok) st_reg <= cst_pkg::ST_BAD_ID;
                            else if (nonempty_reg[rsid]) begin
                                wk_reg   <= 1'b1;
                                wpid_reg <= cst_pkg::PID_W'(head_reg[rsid]);
                                if (head_reg[rsid] == tail_reg[rsid])
                                    nonempty_reg[rsid] <= 1'b0;
                                else
                                    state_reg <= S_LINK;
                            end else if (count_reg[rsid] == CMAX)
                                st_reg <= cst_pkg::ST_OVERFLOW;
                            else count_reg[rsid] <= count_reg[rsid] + 1'b1;
                        end
                        cst_pkg::OP_NAME: begin
                            if (!sid_ok) st_reg <= cst_pkg::ST_BAD_ID;
                            else nout_reg <= cst_pkg::KEY_W'(name_reg[rsid]);
                        end
                        default: ;
                    endcase
                end
                S_LINK: begin
                    head_reg[rsid] <= ram_rdata;
                    state_reg      <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/counting_semaphore_table_top.sv =====
// Counting semaphore table: top level joining front part, request queue
// and back part. Depends on cst_pkg, cst_front, cst_queue, cst_back.
//
// Usage:
//   s_axis carries one request: operation, sem_id, proc_id, init_value,
//   name_key packed in s_tdata. m_axis returns exactly one result per
//   request, in order: status, new_sem_id, caller_blocked, woken_valid,
//   woken_pid, name_out packed in m_tdata.
//   From input accept to m_tvalid a request passes through the queue, then
//   the back part accepts and executes it; a signal that wakes a waiter with
//   others behind it also reads the next-link RAM. A create with a nonzero
//   name key first scans every slot.
//   The back part takes a new request only after it has accepted, executed
//   and held out the result of the last one; the two-entry queue keeps
//   accepting meanwhile.
//   Reset (aresetn low, synchronous) frees all slots and empties all queues.
//   When m_tready is low the result holds and the back part waits; the
//   front keeps accepting until the queue fills.
module counting_semaphore_table_top #(
    parameter int NUM_SEMS   = cst_pkg::NUM_SEMS_DEF,
    parameter int NUM_PROCS  = cst_pkg::NUM_PROCS_DEF,
    parameter int COUNT_BITS = cst_pkg::COUNT_BITS_DEF,
    parameter int NAME_BITS  = cst_pkg::NAME_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[2:0], sem_id[7:3], proc_id[13:8], init_value[29:14], name_key[93:30]
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], new_sem_id[7:3], caller_blocked[8], woken_valid[9],
    // woken_pid[15:10], name_out[79:16]
    output logic [79:0]  m_tdata
);
    cst_pkg::req_t s_req, f_req, b_req;
    logic f_valid, f_ready, b_valid, b_ready;

    assign s_req.operation  = s_tdata[2:0];
    assign s_req.sem_id     = s_tdata[7:3];
    assign s_req.proc_id    = s_tdata[13:8];
    assign s_req.init_value = s_tdata[29:14];
    assign s_req.name_key   = s_tdata[93:30];

    cst_front #(.COUNT_BITS(COUNT_BITS), .NAME_BITS(NAME_BITS)) u_front (
        .s_valid(s_tvalid), .s_ready(s_tready), .s_req(s_req),
        .q_valid(f_valid), .q_ready(f_ready), .q_req(f_req)
    );

    cst_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_req(f_req),
        .out_valid(b_valid), .out_ready(b_ready), .out_req(b_req)
    );

    cst_back #(
        .NUM_SEMS(NUM_SEMS), .NUM_PROCS(NUM_PROCS),
        .COUNT_BITS(COUNT_BITS), .NAME_BITS(NAME_BITS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(b_valid), .q_ready(b_ready), .q_req(b_req),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata)
    );
endmodule

// ===== src/cst_checker.sv =====
// Port-level checker for the semaphore table, bound to the top level.
// Depends on cst_pkg.
module cst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != 3'd7)
        else $error("bad status code");
    a_blk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[2:0] == cst_pkg::ST_OK && !m_tdata[9])
        else $error("blocked result inconsistent");
    a_wake: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[2:0] == cst_pkg::ST_OK && m_tdata[79:16] == '0)
        else $error("wake result inconsistent");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result after reset");
endmodule

bind counting_semaphore_table_top cst_checker u_cst_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== test/counting_semaphore_table_top_tb.sv =====
// Testbench for counting_semaphore_table_top: drives semaphore requests with random
// gaps and stalls, predicts each result with its own semaphore table and checks it.
// Depends on cst_pkg and the RTL of counting_semaphore_table_top.
`timescale 1ns / 1ps

module counting_semaphore_table_top_tb;
    localparam int NSEM = 32;
    localparam int NPROC = 64;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [63:0] name;
        logic [5:0]  wpid;
        logic        woken;
        logic        blocked;
        logic [4:0]  new_id;
        logic [2:0]  status;
    } sem_res_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;

    counting_semaphore_table_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // predicted semaphore table
    logic [15:0] cnt_q [NSEM];
    logic        used_q [NSEM];
    logic [63:0] name_q [NSEM];
    logic [5:0]  head_q [NSEM];
    logic [5:0]  tail_q [NSEM];
    logic        busy_q [NSEM];
    logic [5:0]  link_q [NPROC];

    sem_res_t expected_results[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  hold_off = 0;
    bit  done = 0;

    function automatic sem_res_t predict_sem_op(cst_pkg::req_t r);
        sem_res_t o;
        int slot;
        int s;
        logic [5:0] h;
        o = '0;
        s = r.sem_id;
        case (r.operation)
            cst_pkg::OP_CREATE: begin
                slot = -1;
                if (r.name_key == 0) o.status = cst_pkg::ST_NAME_NULL;
                else begin
                    for (int i = 0; i < NSEM; i++) begin
                        if (used_q[i] && name_q[i] == r.name_key)
                            o.status = cst_pkg::ST_DUPLICATE;
                        if (!used_q[i] && slot < 0) slot = i;
                    end
                    if (o.status == cst_pkg::ST_OK && slot < 0) o.status = cst_pkg::ST_FULL;
                    if (o.status == cst_pkg::ST_OK) begin
                        used_q[slot] = 1;
                        name_q[slot] = r.name_key;
                        cnt_q[slot] = r.init_value;
                        busy_q[slot] = 0;
                        o.new_id = 5'(slot);
                    end
                end
            end
            cst_pkg::OP_FREE: begin
                if (!used_q[s]) o.status = cst_pkg::ST_BAD_ID;
                else if (busy_q[s]) o.status = cst_pkg::ST_WAITERS;
                else begin
                    used_q[s] = 0;
                    cnt_q[s] = 0;
                    name_q[s] = 0;
                end
            end
            cst_pkg::OP_WAIT: begin
                if (!used_q[s]) o.status = cst_pkg::ST_BAD_ID;
                else if (cnt_q[s] > 0) cnt_q[s]--;
                else begin
                    if (busy_q[s]) link_q[tail_q[s]] = r.proc_id;
                    else begin
                        head_q[s] = r.proc_id;
                        busy_q[s] = 1;
                    end
                    tail_q[s] = r.proc_id;
                    o.blocked = 1;
                end
            end
            cst_pkg::OP_SIGNAL: begin
                if (!used_q[s]) o.status = cst_pkg::ST_BAD_ID;
                else if (busy_q[s]) begin
                    h = head_q[s];
                    o.woken = 1;
                    o.wpid = h;
                    if (h == tail_q[s]) busy_q[s] = 0;
                    else head_q[s] = link_q[h];
                end else if (cnt_q[s] == CNT_MAX) o.status = cst_pkg::ST_OVERFLOW;
                else cnt_q[s]++;
            end
            cst_pkg::OP_NAME: begin
                if (!used_q[s]) o.status = cst_pkg::ST_BAD_ID;
                else o.name = name_q[s];
            end
            default: ;
        endcase
        return o;
    endfunction

    // s_tvalid stays high after an accept; drive_idle or the next request's gap lowers it
    task automatic send_request(input logic [2:0] op, input logic [4:0] sid,
                                input logic [5:0] pid, input logic [15:0] init,
                                input logic [63:0] key, input bit no_gap = 0);
        cst_pkg::req_t r;
        int gap;
        r.operation = op;
        r.sem_id = sid;
        r.proc_id = pid;
        r.init_value = init;
        r.name_key = key;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {2'b00, r.name_key, r.init_value, r.proc_id, r.sem_id, r.operation};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_sem_op(r));
    endtask

    task automatic drive_idle;
        s_tvalid <= 0;
    endtask

    task automatic wait_drained;
        drive_idle();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stalls, or a long hold-off while hold_off is set
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 0;
                @(posedge aclk);
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                if (stall != 0) begin
                    m_tready <= 0;
                    repeat (stall) @(posedge aclk);
                end else begin
                    m_tready <= 1;
                    @(posedge aclk);
                    while (!(m_tvalid && m_tready)) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        sem_res_t got, exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                exp = expected_results.pop_front();
                if (got !== exp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d id=%0d blk=%0d wk=%0d pid=%0d nm=%h,",
                                  " got st=%0d id=%0d blk=%0d wk=%0d pid=%0d nm=%h"},
                                 exp.status, exp.new_id, exp.blocked, exp.woken, exp.wpid,
                                 exp.name, got.status, got.new_id, got.blocked, got.woken,
                                 got.wpid, got.name);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT && !done) begin
            $display("counting_semaphore_table_top_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [4:0] live_slot();
        for (int k = 0; k < 4; k++) begin
            int c = $urandom_range(0, NSEM - 1);
            if (used_q[c]) return 5'(c);
        end
        return 5'($urandom_range(0, NSEM - 1));
    endfunction

    task automatic test_directed;
        send_request(cst_pkg::OP_CREATE, 0, 0, 16'd1, 64'd0);
        send_request(cst_pkg::OP_CREATE, 0, 0, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(cst_pkg::OP_CREATE, 0, 0, 16'hFFFF, 64'h1);
        send_request(cst_pkg::OP_CREATE, 0, 0, 16'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(cst_pkg::OP_NAME, 0, 0, 0, 0);
        send_request(cst_pkg::OP_NAME, 31, 0, 0, 0);
        send_request(cst_pkg::OP_SIGNAL, 1, 0, 0, 0);
        send_request(cst_pkg::OP_WAIT, 1, 63, 0, 0);
        send_request(cst_pkg::OP_WAIT, 0, 5, 0, 0);
        send_request(cst_pkg::OP_WAIT, 0, 63, 0, 0);
        send_request(cst_pkg::OP_WAIT, 0, 0, 0, 0);
        send_request(cst_pkg::OP_WAIT, 0, 63, 0, 0);
        send_request(cst_pkg::OP_FREE, 0, 0, 0, 0);
        send_request(cst_pkg::OP_SIGNAL, 0, 0, 0, 0);
        send_request(cst_pkg::OP_SIGNAL, 0, 0, 0, 0);
        send_request(cst_pkg::OP_SIGNAL, 0, 0, 0, 0);
        send_request(cst_pkg::OP_SIGNAL, 0, 0, 0, 0);
        send_request(cst_pkg::OP_FREE, 0, 0, 0, 0);
        send_request(cst_pkg::OP_FREE, 0, 0, 0, 0);
        send_request(3'd5, 0, 0, 0, 0);
        send_request(3'd7, 31, 63, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_table_full;
        for (int i = 0; i < NSEM + 1; i++)
            send_request(cst_pkg::OP_CREATE, 0, 0, 16'($urandom_range(0, 3)),
                         64'h100 + 64'(i));
        wait_drained();
    endtask

    task automatic test_backpressure;
        hold_off = 1;
        fork
            begin
                for (int i = 0; i < 12; i++)
                    send_request(cst_pkg::OP_NAME, live_slot(), 0, 0, 0, 1);
                drive_idle();
            end
            begin
                repeat (200) @(posedge aclk);
                hold_off = 0;
            end
        join
        wait_drained();
    endtask

    task automatic test_random(input int n);
        int kind;
        logic [63:0] key;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            key = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) key = 64'($urandom_range(1, 40));
            if (kind < 8)
                send_request(cst_pkg::OP_CREATE, 5'($urandom), 6'($urandom),
                             16'($urandom), key);
            else if (kind < 10)
                send_request(cst_pkg::OP_CREATE, 5'($urandom), 6'($urandom),
                             16'($urandom), name_q[$urandom_range(0, NSEM - 1)]);
            else if (kind < 18)
                send_request(cst_pkg::OP_FREE, live_slot(), 6'($urandom),
                             16'($urandom), key);
            else if (kind < 50)
                send_request(cst_pkg::OP_WAIT, live_slot(), 6'($urandom),
                             16'($urandom), key);
            else if (kind < 82)
                send_request(cst_pkg::OP_SIGNAL, live_slot(), 6'($urandom),
                             16'($urandom), key);
            else if (kind < 94)
                send_request(cst_pkg::OP_NAME, live_slot(), 6'($urandom),
                             16'($urandom), key);
            else if (kind < 97)
                send_request(3'($urandom_range(0, 7)), 5'($urandom), 6'($urandom),
                             16'($urandom), {$urandom, $urandom});
            else
                send_request(3'($urandom_range(5, 7)), 5'($urandom), 6'($urandom),
                             16'($urandom), key);
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < NSEM; i++) begin
            cnt_q[i] = 0; used_q[i] = 0; name_q[i] = 0;
            head_q[i] = 0; tail_q[i] = 0; busy_q[i] = 0;
        end
        for (int i = 0; i < NPROC; i++) link_q[i] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(300);
        test_random(300);
        repeat (60) @(posedge aclk);
        done = 1;
        if (mismatches == 0 && expected_results.size() == 0)
            $display("counting_semaphore_table_top_tb OK");
        else
            $display("counting_semaphore_table_top_tb NOT OK");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/cst_pkg.sv
src/cst_ram.sv
src/cst_queue.sv
src/cst_front.sv
src/cst_back.sv
src/counting_semaphore_table_top.sv
src/cst_checker.sv
test/counting_semaphore_table_top_tb.sv
